// ===== design/jac_pkg.sv =====
// ----------------------------------------------------------------------------
// jac_pkg: shared types and constants for the joystick axis controller mapper
// Field widths, register indexes, reset values, the control state type and
// the structures passed between the top level and its submodules.
// ----------------------------------------------------------------------------
package jac_pkg;

  // Field widths
  localparam int SAMPLE_W   = 10;
  localparam int DZ_W       = 9;
  localparam int TIME_W     = 32;
  localparam int CC_W       = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int S_TDATA_W  = 48;
  localparam int M_TDATA_W  = 16;

  // Scaled distance is at most 1023 * 127, which needs 17 bits
  localparam int NUM_W       = 17;
  localparam int DIV_COUNT_W = $clog2(NUM_W + 1);

  localparam logic [CC_W-1:0] CC_MAX  = 7'd127;
  localparam logic [CC_W-1:0] CC_ZERO = 7'd0;

  // Reset values of the configuration registers
  localparam logic [SAMPLE_W-1:0] RST_CENTER    = 10'd512;
  localparam logic [DZ_W-1:0]     RST_DZ        = 9'd20;
  localparam logic [SAMPLE_W-1:0] RST_UPPER_END = 10'd1023;
  localparam logic [SAMPLE_W-1:0] RST_LOWER_END = 10'd0;
  localparam logic [SAMPLE_W-1:0] RST_THRESHOLD = 10'd4;
  localparam logic [TIME_W-1:0]   RST_TIMEOUT   = 32'd500;
  localparam logic [CC_W-1:0]     RST_UPPER_CC  = 7'd1;
  localparam logic [CC_W-1:0]     RST_LOWER_CC  = 7'd2;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER    = 3'd0,
    REG_DEADZONE  = 3'd1,
    REG_UPPER_END = 3'd2,
    REG_LOWER_END = 3'd3,
    REG_THRESHOLD = 3'd4,
    REG_TIMEOUT   = 3'd5,
    REG_UPPER_CC  = 3'd6,
    REG_LOWER_CC  = 3'd7
  } cfg_reg_t;

  // Control sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_SEND,
    ST_DZ_LO,
    ST_DZ_HI
  } state_t;

  // One controller change message
  typedef struct packed {
    logic [CC_W-1:0] number;
    logic [CC_W-1:0] value;
    logic            last;
  } msg_t;

  // Status of the serial divider
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== design/jac_serial_div.sv =====
// ----------------------------------------------------------------------------
// jac_serial_div: bit-serial restoring divider
// Produces one quotient bit per cycle; the dividend shifts out at the top of
// a shift register while the quotient bits shift in at the bottom.
// ----------------------------------------------------------------------------
module jac_serial_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [jac_pkg::NUM_W-1:0]      dividend,
  input  logic [jac_pkg::SAMPLE_W-1:0]   divisor,
  output jac_pkg::div_stat_t             stat,
  output logic [jac_pkg::NUM_W-1:0]      quotient
);

  logic [jac_pkg::NUM_W-1:0]       dq;
  logic [jac_pkg::SAMPLE_W-1:0]    rem;
  logic [jac_pkg::SAMPLE_W-1:0]    divisor_q;
  logic [jac_pkg::DIV_COUNT_W-1:0] count;
  logic                            busy;
  logic                            done;
  logic [jac_pkg::SAMPLE_W:0]      rem_sh;
  logic [jac_pkg::SAMPLE_W:0]      rem_diff;
  logic                            fits;

  // One restoring step: bring down the next dividend bit and try a subtract.
  always_comb begin
    rem_sh   = {rem, dq[jac_pkg::NUM_W-1]};
    rem_diff = rem_sh - {1'b0, divisor_q};
    fits     = rem_sh >= {1'b0, divisor_q};
  end

  // Step counter and status flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= jac_pkg::DIV_COUNT_W'(jac_pkg::NUM_W);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == jac_pkg::DIV_COUNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Shift register holding the partial remainder and the quotient.
  always_ff @(posedge clk) begin
    if (start) begin
      dq        <= dividend;
      rem       <= '0;
      divisor_q <= divisor;
    end else if (busy) begin
      dq  <= {dq[jac_pkg::NUM_W-2:0], fits};
      rem <= fits ? rem_diff[jac_pkg::SAMPLE_W-1:0] : rem_sh[jac_pkg::SAMPLE_W-1:0];
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = dq;

endmodule

// ===== design/jac_msg_fifo.sv =====
// ----------------------------------------------------------------------------
// jac_msg_fifo: two-word output queue
// Holds controller change messages until the downstream side takes them, so
// that the sequencer can move on while a word waits.
// ----------------------------------------------------------------------------
module jac_msg_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  jac_pkg::msg_t push_msg,
  output logic          room,
  output logic          out_valid,
  input  logic          out_ready,
  output jac_pkg::msg_t out_msg
);

  jac_pkg::msg_t entries [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic          pop;

  assign pop       = out_valid && out_ready;
  assign room      = count != 2'd2;
  assign out_valid = count != 2'd0;
  assign out_msg   = entries[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Word storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_msg;
    end
  end

endmodule

// ===== design/joystick_axis_to_midi_cc.sv =====
// ----------------------------------------------------------------------------
// joystick_axis_to_midi_cc: joystick axis to controller change mapper
// Tracks axis activity, applies a deadzone around the centre and scales the
// offset to a 0..127 controller value, sending only changed values.
// ----------------------------------------------------------------------------
// An accepted sample that yields no message (inactive, or already centred)
// returns from evaluation to idle; a fixed value (zero divisor or end on the
// wrong side) passes through the send state, a deadzone entry through both
// deadzone states, each writing its word once the queue has room, and a
// scaled offset through the divide state, where a bit-serial restoring
// divider makes one of its 17 quotient bits per cycle. Results go through a
// two-word output queue, so a waiting word stalls the block only once the
// queue is full. The user must write configuration through cfg_we,
// cfg_index and cfg_data only while the block is idle; it does not enforce this.
module joystick_axis_to_midi_cc (
  input  logic                              clk,
  input  logic                              rst,
  // s_tdata: axis_sample [9:0], now_ms [41:10], zero [47:42]
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [jac_pkg::S_TDATA_W-1:0]     s_tdata,
  // m_tdata: controller_number [6:0], controller_value [13:7], zero [15:14]
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [jac_pkg::M_TDATA_W-1:0]     m_tdata,
  output logic                              m_tlast,
  input  logic                              cfg_we,
  input  logic [jac_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [jac_pkg::CFG_DATA_W-1:0]    cfg_data
);

  // Configuration registers
  logic [jac_pkg::SAMPLE_W-1:0] center_value;
  logic [jac_pkg::DZ_W-1:0]     deadzone_half_width;
  logic [jac_pkg::SAMPLE_W-1:0] upper_end;
  logic [jac_pkg::SAMPLE_W-1:0] lower_end;
  logic [jac_pkg::SAMPLE_W-1:0] move_threshold;
  logic [jac_pkg::TIME_W-1:0]   timeout_ms;
  logic [jac_pkg::CC_W-1:0]     upper_controller;
  logic [jac_pkg::CC_W-1:0]     lower_controller;

  // Tracking state
  logic [jac_pkg::SAMPLE_W-1:0] previous_sample;
  logic [jac_pkg::TIME_W-1:0]   last_activity_ms;
  logic [jac_pkg::CC_W-1:0]     last_sent_value;
  logic                         is_centered;

  // Current item
  logic [jac_pkg::SAMPLE_W-1:0] sample_q;
  logic [jac_pkg::TIME_W-1:0]   now_q;
  logic                         sel_upper;
  logic [jac_pkg::CC_W-1:0]     cc_value;

  jac_pkg::state_t state;
  jac_pkg::state_t state_next;

  // Evaluation signals
  logic [jac_pkg::SAMPLE_W-1:0] delta;
  logic                         moved;
  logic [jac_pkg::TIME_W-1:0]   act_time;
  logic [jac_pkg::TIME_W-1:0]   elapsed;
  logic                         active;
  logic [jac_pkg::SAMPLE_W:0]   c_plus;
  logic [jac_pkg::SAMPLE_W:0]   s_plus;
  logic                         in_dz;
  logic                         upper;
  logic [jac_pkg::SAMPLE_W-1:0] offset_mag;
  logic [jac_pkg::NUM_W-1:0]    mag_num;
  logic [jac_pkg::SAMPLE_W-1:0] end_sel;
  logic                         den_zero;
  logic                         den_ok;
  logic [jac_pkg::SAMPLE_W-1:0] den_mag;
  logic [jac_pkg::CC_W-1:0]     quot_sat;

  // Sequencer outputs and unit connections
  logic                         div_start;
  jac_pkg::div_stat_t           div_stat;
  logic [jac_pkg::NUM_W-1:0]    div_quot;
  logic                         fifo_push;
  jac_pkg::msg_t                push_msg;
  logic                         fifo_room;
  jac_pkg::msg_t                out_msg;

  // Activity, deadzone and section decisions for the held sample.
  always_comb begin
    delta      = (sample_q > previous_sample) ? sample_q - previous_sample
                                              : previous_sample - sample_q;
    moved      = delta > move_threshold;
    act_time   = moved ? now_q : last_activity_ms;
    elapsed    = now_q - act_time;
    active     = elapsed < timeout_ms;
    c_plus     = {1'b0, center_value} + {2'b00, deadzone_half_width};
    s_plus     = {1'b0, sample_q} + {2'b00, deadzone_half_width};
    in_dz      = ({1'b0, sample_q} <= c_plus) && (s_plus >= {1'b0, center_value});
    upper      = {1'b0, sample_q} > c_plus;
    offset_mag = upper ? sample_q - center_value : center_value - sample_q;
    mag_num    = {offset_mag, 7'b0} - {7'b0, offset_mag};
    end_sel    = upper ? upper_end : lower_end;
    den_zero   = end_sel == center_value;
    den_ok     = upper ? (end_sel > center_value) : (end_sel < center_value);
    den_mag    = upper ? end_sel - center_value : center_value - end_sel;
    quot_sat   = (div_quot > jac_pkg::NUM_W'(jac_pkg::CC_MAX)) ? jac_pkg::CC_MAX
                                                               : div_quot[jac_pkg::CC_W-1:0];
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      jac_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          state_next = jac_pkg::ST_EVAL;
        end
      end
      jac_pkg::ST_EVAL: begin
        priority if (!active) begin
          state_next = jac_pkg::ST_IDLE;
        end else if (in_dz) begin
          state_next = is_centered ? jac_pkg::ST_IDLE : jac_pkg::ST_DZ_LO;
        end else if (den_zero || !den_ok) begin
          state_next = jac_pkg::ST_SEND;
        end else begin
          state_next = jac_pkg::ST_DIV;
        end
      end
      jac_pkg::ST_DIV: begin
        if (div_stat.done) begin
          state_next = jac_pkg::ST_SEND;
        end
      end
      jac_pkg::ST_SEND: begin
        if (cc_value == last_sent_value || fifo_room) begin
          state_next = jac_pkg::ST_IDLE;
        end
      end
      jac_pkg::ST_DZ_LO: begin
        if (fifo_room) begin
          state_next = jac_pkg::ST_DZ_HI;
        end
      end
      jac_pkg::ST_DZ_HI: begin
        if (fifo_room) begin
          state_next = jac_pkg::ST_IDLE;
        end
      end
      default: state_next = jac_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    s_tready        = 1'b0;
    div_start       = 1'b0;
    fifo_push       = 1'b0;
    push_msg.number = lower_controller;
    push_msg.value  = jac_pkg::CC_ZERO;
    push_msg.last   = 1'b0;
    unique case (state)
      jac_pkg::ST_IDLE: begin
        s_tready = 1'b1;
      end
      jac_pkg::ST_EVAL: begin
        div_start = active && !in_dz && !den_zero && den_ok;
      end
      jac_pkg::ST_SEND: begin
        fifo_push       = (cc_value != last_sent_value) && fifo_room;
        push_msg.number = sel_upper ? upper_controller : lower_controller;
        push_msg.value  = cc_value;
        push_msg.last   = 1'b1;
      end
      jac_pkg::ST_DZ_LO: begin
        fifo_push = fifo_room;
      end
      jac_pkg::ST_DZ_HI: begin
        fifo_push       = fifo_room;
        push_msg.number = upper_controller;
        push_msg.last   = 1'b1;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  // Control state, configuration and tracking registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= jac_pkg::ST_IDLE;
      center_value        <= jac_pkg::RST_CENTER;
      deadzone_half_width <= jac_pkg::RST_DZ;
      upper_end           <= jac_pkg::RST_UPPER_END;
      lower_end           <= jac_pkg::RST_LOWER_END;
      move_threshold      <= jac_pkg::RST_THRESHOLD;
      timeout_ms          <= jac_pkg::RST_TIMEOUT;
      upper_controller    <= jac_pkg::RST_UPPER_CC;
      lower_controller    <= jac_pkg::RST_LOWER_CC;
      previous_sample     <= '0;
      last_activity_ms    <= '0;
      last_sent_value     <= '0;
      is_centered         <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (jac_pkg::cfg_reg_t'(cfg_index))
          jac_pkg::REG_CENTER:    center_value        <= cfg_data[jac_pkg::SAMPLE_W-1:0];
          jac_pkg::REG_DEADZONE:  deadzone_half_width <= cfg_data[jac_pkg::DZ_W-1:0];
          jac_pkg::REG_UPPER_END: upper_end           <= cfg_data[jac_pkg::SAMPLE_W-1:0];
          jac_pkg::REG_LOWER_END: lower_end           <= cfg_data[jac_pkg::SAMPLE_W-1:0];
          jac_pkg::REG_THRESHOLD: move_threshold      <= cfg_data[jac_pkg::SAMPLE_W-1:0];
          jac_pkg::REG_TIMEOUT:   timeout_ms          <= cfg_data[jac_pkg::TIME_W-1:0];
          jac_pkg::REG_UPPER_CC:  upper_controller    <= cfg_data[jac_pkg::CC_W-1:0];
          jac_pkg::REG_LOWER_CC:  lower_controller    <= cfg_data[jac_pkg::CC_W-1:0];
          default:                center_value        <= center_value;
        endcase
      end
      if (state == jac_pkg::ST_EVAL) begin
        if (moved) begin
          last_activity_ms <= now_q;
        end
        if (active) begin
          previous_sample <= sample_q;
        end
      end
      if (state == jac_pkg::ST_SEND && fifo_push) begin
        last_sent_value <= cc_value;
        is_centered     <= 1'b0;
      end
      if (state == jac_pkg::ST_DZ_HI && fifo_push) begin
        is_centered <= 1'b1;
      end
    end
  end

  // Item payload and the value to be sent.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      sample_q <= s_tdata[jac_pkg::SAMPLE_W-1:0];
      now_q    <= s_tdata[jac_pkg::SAMPLE_W +: jac_pkg::TIME_W];
    end
    if (state == jac_pkg::ST_EVAL) begin
      sel_upper <= upper;
      if (den_zero) begin
        cc_value <= jac_pkg::CC_MAX;
      end else if (!den_ok) begin
        cc_value <= jac_pkg::CC_ZERO;
      end
    end
    if (state == jac_pkg::ST_DIV && div_stat.done) begin
      cc_value <= quot_sat;
    end
  end

  jac_serial_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mag_num),
    .divisor  (den_mag),
    .stat     (div_stat),
    .quotient (div_quot)
  );

  jac_msg_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (fifo_push),
    .push_msg  (push_msg),
    .room      (fifo_room),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_msg   (out_msg)
  );

  // Output word packing.
  assign m_tdata = {2'b00, out_msg.value, out_msg.number};
  assign m_tlast = out_msg.last;

  // A word is only written when the queue has space for it.
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    fifo_push |-> fifo_room)
    else $error("word written to a full output queue");

  // The divider is never running while a new sample can be taken.
  a_ready_div_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !div_stat.busy)
    else $error("sample accepted while the divider is busy");

  // A finished quotient always finds the sequencer waiting for it.
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> state == jac_pkg::ST_DIV)
    else $error("divider finished outside the divide state");

  // The second deadzone word marks the axis as centred.
  a_centred: assert property (@(posedge clk) disable iff (rst)
    (state == jac_pkg::ST_DZ_HI && fifo_push) |=> is_centered)
    else $error("deadzone entry did not set the centred flag");

  // A sent value becomes the last sent value.
  a_last_sent: assert property (@(posedge clk) disable iff (rst)
    (state == jac_pkg::ST_SEND && fifo_push) |=> last_sent_value == $past(cc_value))
    else $error("last sent value not updated after a send");

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the joystick axis controller mapper
// A directed table covers reset behaviour, deadzone entry, both sections,
// zero divisors, wrong-side ends, timeouts and time wrap. Random phases then
// run under fresh settings and varied idling. Every word leaving the block is
// checked against a row's typed words or a cycle-free model of the mapping.
// ----------------------------------------------------------------------------
module testbench;

  localparam int HALF_PERIOD     = 4;
  // Long enough for a busy block to finish a scaled sample twice over.
  localparam int SETTLE_CYCLES   = 45;
  localparam int HOLD_CYCLES     = 400;
  localparam int RANDOM_PHASES   = 6;
  localparam int WORDS_PER_PHASE = 215;

  logic                           clk       = 1'b0;
  logic                           rst       = 1'b1;
  logic                           s_tvalid  = 1'b0;
  logic                           s_tready;
  logic [jac_pkg::S_TDATA_W-1:0]  s_tdata   = '0;
  logic                           m_tvalid;
  logic                           m_tready  = 1'b0;
  logic [jac_pkg::M_TDATA_W-1:0]  m_tdata;
  logic                           m_tlast;
  logic                           cfg_we    = 1'b0;
  logic [jac_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [jac_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  // Idling rates in percent, and the long receiver hold-off.
  int   tx_idle_pct = 0;
  int   rx_idle_pct = 0;
  logic hold_go     = 1'b0;
  logic sink_hold   = 1'b0;

  int            fail_count = 0;
  bit            words_since_cfg = 1'b0;
  jac_pkg::msg_t cc_expected[$];

  // Mirror of the configuration registers.
  logic [jac_pkg::SAMPLE_W-1:0] m_center    = jac_pkg::RST_CENTER;
  logic [jac_pkg::DZ_W-1:0]     m_deadzone  = jac_pkg::RST_DZ;
  logic [jac_pkg::SAMPLE_W-1:0] m_upper_end = jac_pkg::RST_UPPER_END;
  logic [jac_pkg::SAMPLE_W-1:0] m_lower_end = jac_pkg::RST_LOWER_END;
  logic [jac_pkg::SAMPLE_W-1:0] m_threshold = jac_pkg::RST_THRESHOLD;
  logic [jac_pkg::TIME_W-1:0]   m_timeout   = jac_pkg::RST_TIMEOUT;
  logic [jac_pkg::CC_W-1:0]     m_upper_cc  = jac_pkg::RST_UPPER_CC;
  logic [jac_pkg::CC_W-1:0]     m_lower_cc  = jac_pkg::RST_LOWER_CC;

  // Mirror of the tracking state.
  logic [jac_pkg::SAMPLE_W-1:0] prev_sample    = '0;
  logic [jac_pkg::TIME_W-1:0]   last_active_ms = '0;
  logic [jac_pkg::CC_W-1:0]     last_value     = '0;
  bit                           centred        = 1'b0;

  typedef struct {
    bit                           is_reg;
    jac_pkg::cfg_reg_t            idx;
    logic [31:0]                  data;
    logic [jac_pkg::SAMPLE_W-1:0] smp;
    logic [jac_pkg::TIME_W-1:0]   t;
    int                           n;
    jac_pkg::msg_t                r0;
    jac_pkg::msg_t                r1;
  } stim_row_t;

  stim_row_t directed_rows[$];

  joystick_axis_to_midi_cc i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #HALF_PERIOD clk = ~clk;
  end

  initial begin
    #4000000;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic note_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    fail_count++;
  endtask

  // Offset from the centre scaled to 0..127, truncating toward zero.
  function automatic int scale_cc(input int s, input int c, input int e);
    int q;
    if (e == c) return 127;
    q = ((s - c) * 127) / (e - c);
    if (q > 127) q = 127;
    if (q < 0) q = 0;
    return q;
  endfunction

  // Works out the messages one sample causes and advances the tracking state.
  function automatic int map_sample(input logic [jac_pkg::SAMPLE_W-1:0] smp,
                                    input logic [jac_pkg::TIME_W-1:0] t,
                                    output jac_pkg::msg_t r0, output jac_pkg::msg_t r1);
    logic [jac_pkg::SAMPLE_W-1:0] moved;
    logic [jac_pkg::TIME_W-1:0]   idle_ms;
    logic [jac_pkg::CC_W-1:0]     cc;
    int s, c, dz, v, n;
    n  = 0;
    r0 = '0;
    r1 = '0;
    moved = (smp > prev_sample) ? smp - prev_sample : prev_sample - smp;
    if (moved > m_threshold) last_active_ms = t;
    idle_ms = t - last_active_ms;
    if (idle_ms >= m_timeout) return 0;

    s  = int'(smp);
    c  = int'(m_center);
    dz = int'(m_deadzone);
    if (s <= c + dz && s >= c - dz) begin
      // Entering the deadzone zeroes both controllers once.
      if (!centred) begin
        r0 = '{m_lower_cc, jac_pkg::CC_ZERO, 1'b0};
        r1 = '{m_upper_cc, jac_pkg::CC_ZERO, 1'b1};
        n = 2;
        centred = 1'b1;
      end
    end else begin
      if (s >= c + dz) begin
        v  = scale_cc(s, c, int'(m_upper_end));
        cc = m_upper_cc;
      end else begin
        v  = scale_cc(s, c, int'(m_lower_end));
        cc = m_lower_cc;
      end
      if (v != int'(last_value)) begin
        r0 = '{cc, v[jac_pkg::CC_W-1:0], 1'b1};
        n = 1;
        last_value = v[jac_pkg::CC_W-1:0];
        centred = 1'b0;
      end
    end
    prev_sample = smp;
    return n;
  endfunction

  // Receiver side: random readiness, an optional long hold, and the checks.
  always @(posedge clk) begin : sink_side
    jac_pkg::msg_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= !sink_hold && ($urandom_range(99) >= rx_idle_pct);
    end
    if (!rst && m_tvalid && m_tready) begin
      if (cc_expected.size() == 0) begin
        note_mismatch($sformatf("unexpected word: number %0d value %0d last %0b",
                                m_tdata[6:0], m_tdata[13:7], m_tlast));
      end else begin
        want = cc_expected.pop_front();
        if (m_tdata[6:0] != want.number)
          note_mismatch($sformatf("controller number %0d, expected %0d",
                                  m_tdata[6:0], want.number));
        if (m_tdata[13:7] != want.value)
          note_mismatch($sformatf("controller value %0d, expected %0d",
                                  m_tdata[13:7], want.value));
        if (m_tlast != want.last)
          note_mismatch($sformatf("last flag %0b, expected %0b", m_tlast, want.last));
      end
    end
  end

  // Long receiver hold-off so that the output queue fills and input stalls.
  initial begin : pressure
    wait (hold_go);
    @(posedge clk);
    sink_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    sink_hold <= 1'b0;
  end

  // Waits until every expected word has come and the block has gone quiet.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (cc_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input jac_pkg::cfg_reg_t idx, input logic [31:0] val);
    if (words_since_cfg) begin
      settle();
      words_since_cfg = 1'b0;
    end
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      jac_pkg::REG_CENTER:    m_center    = val[jac_pkg::SAMPLE_W-1:0];
      jac_pkg::REG_DEADZONE:  m_deadzone  = val[jac_pkg::DZ_W-1:0];
      jac_pkg::REG_UPPER_END: m_upper_end = val[jac_pkg::SAMPLE_W-1:0];
      jac_pkg::REG_LOWER_END: m_lower_end = val[jac_pkg::SAMPLE_W-1:0];
      jac_pkg::REG_THRESHOLD: m_threshold = val[jac_pkg::SAMPLE_W-1:0];
      jac_pkg::REG_TIMEOUT:   m_timeout   = val[jac_pkg::TIME_W-1:0];
      jac_pkg::REG_UPPER_CC:  m_upper_cc  = val[jac_pkg::CC_W-1:0];
      jac_pkg::REG_LOWER_CC:  m_lower_cc  = val[jac_pkg::CC_W-1:0];
      default: ;
    endcase
  endtask

  // Offers one sample word; a typed count overrides the computed messages.
  task automatic send_word(input logic [jac_pkg::SAMPLE_W-1:0] smp,
                           input logic [jac_pkg::TIME_W-1:0] t,
                           input int typed_n, input jac_pkg::msg_t typed0,
                           input jac_pkg::msg_t typed1);
    jac_pkg::msg_t p0, p1;
    int            n;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, t, smp};
    do @(posedge clk); while (!s_tready);
    n = map_sample(smp, t, p0, p1);
    if (typed_n >= 0) begin
      n  = typed_n;
      p0 = typed0;
      p1 = typed1;
    end
    if (n > 0) cc_expected.push_back(p0);
    if (n > 1) cc_expected.push_back(p1);
    words_since_cfg = 1'b1;
  endtask

  function automatic jac_pkg::msg_t cc_msg(input int num, input int val, input bit last);
    cc_msg = '{num[jac_pkg::CC_W-1:0], val[jac_pkg::CC_W-1:0], last};
  endfunction

  function automatic void row_reg(input jac_pkg::cfg_reg_t idx, input logic [31:0] val);
    stim_row_t r;
    r.is_reg = 1'b1;
    r.idx    = idx;
    r.data   = val;
    r.smp    = '0;
    r.t      = '0;
    r.n      = -1;
    r.r0     = '0;
    r.r1     = '0;
    directed_rows.push_back(r);
  endfunction

  function automatic void row_word(input logic [jac_pkg::SAMPLE_W-1:0] smp,
                                   input logic [jac_pkg::TIME_W-1:0] t,
                                   input int n = -1, input jac_pkg::msg_t r0 = '0,
                                   input jac_pkg::msg_t r1 = '0);
    stim_row_t r;
    r.is_reg = 1'b0;
    r.idx    = jac_pkg::REG_CENTER;
    r.data   = '0;
    r.smp    = smp;
    r.t      = t;
    r.n      = n;
    r.r0     = r0;
    r.r1     = r1;
    directed_rows.push_back(r);
  endfunction

  initial begin : stimulus
    logic [jac_pkg::SAMPLE_W-1:0] smp;
    logic [jac_pkg::TIME_W-1:0]   t;
    int cen, dzw, up, lo, thr, tmo, lim, nv;

    // Reset settings: deadzone entry, both sections, repeats and timeouts.
    row_word(10'd512,  32'd10, 2, cc_msg(2, 0, 1'b0), cc_msg(1, 0, 1'b1));
    row_word(10'd515,  32'd20, 0);
    row_word(10'd1023, 32'd30, 1, cc_msg(1, 127, 1'b1));
    row_word(10'd0,    32'd40, 0);
    row_word(10'd532,  32'd50, 2, cc_msg(2, 0, 1'b0), cc_msg(1, 0, 1'b1));
    row_word(10'd533,  32'd60);
    row_word(10'd491,  32'd70);
    row_word(10'd492,  32'd80);
    row_word(10'd492,  32'd580);
    row_word(10'd1023, 32'hFFFF_FFFF);
    row_word(10'd1000, 32'h0000_0000);
    // A zero timeout keeps the block asleep whatever moves.
    row_reg(jac_pkg::REG_TIMEOUT, 32'd0);
    row_word(10'd0,    32'd100, 0);
    row_word(10'd1023, 32'd200, 0);
    // Zero divisor above, wrong-side end below, no deadzone, any move counts.
    row_reg(jac_pkg::REG_TIMEOUT,   32'hFFFF_FFFF);
    row_reg(jac_pkg::REG_UPPER_END, 32'd512);
    row_reg(jac_pkg::REG_LOWER_END, 32'd1023);
    row_reg(jac_pkg::REG_UPPER_CC,  32'd127);
    row_reg(jac_pkg::REG_LOWER_CC,  32'd0);
    row_reg(jac_pkg::REG_THRESHOLD, 32'd0);
    row_reg(jac_pkg::REG_DEADZONE,  32'd0);
    row_word(10'd513, 32'd300);
    row_word(10'd0,   32'd301);
    row_word(10'd512, 32'd302);
    row_word(10'd513, 32'd303);
    // Deadzone reaching below zero.
    row_reg(jac_pkg::REG_CENTER,    32'd0);
    row_reg(jac_pkg::REG_DEADZONE,  32'd511);
    row_reg(jac_pkg::REG_UPPER_END, 32'd1023);
    row_reg(jac_pkg::REG_LOWER_END, 32'd0);
    row_word(10'd0,   32'd400);
    row_word(10'd511, 32'd401);
    row_word(10'd512, 32'd402);
    // Deadzone reaching above the top, movement never counts.
    row_reg(jac_pkg::REG_CENTER,    32'd1023);
    row_reg(jac_pkg::REG_UPPER_END, 32'd0);
    row_reg(jac_pkg::REG_THRESHOLD, 32'd1023);
    row_word(10'd1023, 32'd500);
    row_word(10'd511,  32'd501);
    row_word(10'd0,    32'd502);
    row_word(10'd1023, 32'd503);

    tx_idle_pct = 29;
    rx_idle_pct <= 72;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_reg) begin
        write_reg(directed_rows[i].idx, directed_rows[i].data);
      end else begin
        send_word(directed_rows[i].smp, directed_rows[i].t, directed_rows[i].n,
                  directed_rows[i].r0, directed_rows[i].r1);
      end
    end

    // Random phases, each under fresh settings; idling changes every two.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph / 2)
        0: begin
          tx_idle_pct = 29;
          rx_idle_pct <= 72;
        end
        1: begin
          tx_idle_pct = 72;
          rx_idle_pct <= 29;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct <= 0;
        end
      endcase

      cen = int'($urandom_range(1023));
      dzw = ($urandom_range(3) == 0) ? int'($urandom_range(511)) : int'($urandom_range(40));
      up  = ($urandom_range(4) == 0) ? int'($urandom_range(1023))
                                     : int'($urandom_range(1023, cen));
      lo  = ($urandom_range(4) == 0) ? int'($urandom_range(1023)) : int'($urandom_range(cen));
      thr = ($urandom_range(4) == 0) ? int'($urandom_range(1023)) : int'($urandom_range(12));
      tmo = ($urandom_range(9) == 0) ? int'($urandom()) : int'($urandom_range(2000, 40));
      write_reg(jac_pkg::REG_CENTER,    cen);
      write_reg(jac_pkg::REG_DEADZONE,  dzw);
      write_reg(jac_pkg::REG_UPPER_END, up);
      write_reg(jac_pkg::REG_LOWER_END, lo);
      write_reg(jac_pkg::REG_THRESHOLD, thr);
      write_reg(jac_pkg::REG_TIMEOUT,   tmo);
      write_reg(jac_pkg::REG_UPPER_CC,  $urandom_range(127));
      write_reg(jac_pkg::REG_LOWER_CC,  $urandom_range(127));

      t   = $urandom();
      smp = jac_pkg::SAMPLE_W'($urandom_range(1023));
      lim = ((thr > 30) ? 30 : thr) + 3;
      for (int k = 0; k < WORDS_PER_PHASE; k++) begin
        if (ph == 4 && k == 40) hold_go <= 1'b1;
        // Mostly a wandering stick, with jumps and visits around the centre.
        case ($urandom_range(9))
          0:       nv = int'($urandom_range(1023));
          1, 2:    nv = cen + int'($urandom_range(2 * dzw + 6)) - (dzw + 3);
          default: nv = int'(smp) + int'($urandom_range(2 * lim)) - lim;
        endcase
        if (nv < 0) nv = 0;
        if (nv > 1023) nv = 1023;
        smp = nv[jac_pkg::SAMPLE_W-1:0];
        // Time mostly creeps forward, now and then past the timeout.
        if ($urandom_range(24) == 0) t = t + tmo + $urandom_range(200);
        else t = t + $urandom_range(15);
        send_word(smp, t, -1, '0, '0);
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
